>>> rtl/stack_machine_20bit_unit_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the 20-bit stack machine
// Shared concurrent assertion forms, clocked and reset-gated.
// -----------------------------------------------------------------------------
`ifndef STACK_MACHINE_20BIT_UNIT_MACROS_SVH
`define STACK_MACHINE_20BIT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SM20_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SM20_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/sm20_pkg.sv
// -----------------------------------------------------------------------------
// sm20_pkg
// Widths, instruction codes and shared types of the 20-bit stack machine.
// -----------------------------------------------------------------------------
`default_nettype none

package sm20_pkg;

	// Field widths.
	localparam int WORD_W = 20;
	localparam int MODE_W = 3;
	localparam int FILL_W = 12;

	// Default number of stack entries.
	localparam int STACK_DEPTH_DEF = 2048;

	// Instruction codes.
	localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DUP  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ADD  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SUB  = 3'd4;

	// Control flags from the execute logic.
	typedef struct packed {
		logic wr_en;
		logic err;
		logic fail;
	} exec_flags_t;

endpackage

`default_nettype wire

>>> rtl/sm20_ram.sv
// -----------------------------------------------------------------------------
// sm20_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module sm20_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/sm20_exec.sv
// -----------------------------------------------------------------------------
// sm20_exec
// Execute step: checks one instruction against the stack and forms the update.
// -----------------------------------------------------------------------------
`default_nettype none

module sm20_exec #(
	parameter int STACK_DEPTH = sm20_pkg::STACK_DEPTH_DEF
) (
	input  wire logic [sm20_pkg::MODE_W-1:0]        mode,
	input  wire logic [sm20_pkg::WORD_W-1:0]        value,
	input  wire logic [$clog2(STACK_DEPTH+1)-1:0]   cnt,
	input  wire logic                               err,
	input  wire logic [sm20_pkg::WORD_W-1:0]        tos,
	input  wire logic [sm20_pkg::WORD_W-1:0]        nos,
	output logic      [$clog2(STACK_DEPTH+1)-1:0]   cnt_nxt,
	output logic      [sm20_pkg::WORD_W-1:0]        tos_nxt,
	output logic      [$clog2(STACK_DEPTH)-1:0]     waddr,
	output logic      [sm20_pkg::WORD_W-1:0]        wdata,
	output sm20_pkg::exec_flags_t                   flags
);

	localparam int FW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int WW = sm20_pkg::WORD_W;

	logic [FW-1:0] cnt_m1;
	logic [FW-1:0] cnt_m2;
	logic          full;
	logic          empty;
	logic          short;
	logic [WW:0]   sum;
	logic          err_nxt;

	assign cnt_m1 = cnt - FW'(1);
	assign cnt_m2 = cnt - FW'(2);
	assign full   = (cnt >= FW'(STACK_DEPTH));
	assign empty  = (cnt == '0);
	assign short  = (cnt < FW'(2));
	assign sum    = {1'b0, tos} + {1'b0, nos};

	// Instruction decode; a failing instruction leaves the stack untouched.
	always_comb begin
		cnt_nxt       = cnt;
		tos_nxt       = tos;
		waddr         = cnt[AW-1:0];
		wdata         = value;
		err_nxt       = err;
		flags.wr_en   = 1'b0;
		if (!err) begin
			case (mode)
				sm20_pkg::MODE_PUSH: begin
					if (full) begin
						err_nxt = 1'b1;
					end else begin
						flags.wr_en = 1'b1;
						cnt_nxt     = cnt + FW'(1);
						tos_nxt     = value;
					end
				end
				sm20_pkg::MODE_POP: begin
					if (empty) begin
						err_nxt = 1'b1;
					end else begin
						cnt_nxt = cnt_m1;
						tos_nxt = nos;
					end
				end
				sm20_pkg::MODE_DUP: begin
					if (empty || full) begin
						err_nxt = 1'b1;
					end else begin
						flags.wr_en = 1'b1;
						wdata       = tos;
						cnt_nxt     = cnt + FW'(1);
					end
				end
				sm20_pkg::MODE_ADD: begin
					if (short || sum[WW]) begin
						err_nxt = 1'b1;
					end else begin
						flags.wr_en = 1'b1;
						waddr       = cnt_m2[AW-1:0];
						wdata       = sum[WW-1:0];
						cnt_nxt     = cnt_m1;
						tos_nxt     = sum[WW-1:0];
					end
				end
				sm20_pkg::MODE_SUB: begin
					if (short || (tos < nos)) begin
						err_nxt = 1'b1;
					end else begin
						flags.wr_en = 1'b1;
						waddr       = cnt_m2[AW-1:0];
						wdata       = tos - nos;
						cnt_nxt     = cnt_m1;
						tos_nxt     = tos - nos;
					end
				end
				default: begin
				end
			endcase
		end
		// Sticky error and the failed indication of the result.
		flags.err  = err_nxt;
		flags.fail = err_nxt || (cnt_nxt == '0);
	end

endmodule

`default_nettype wire

>>> rtl/stack_machine_20bit_unit.sv
// -----------------------------------------------------------------------------
// stack_machine_20bit_unit
// Stack machine on unsigned 20-bit words with the stack held in a RAM.
// -----------------------------------------------------------------------------
// Sequence: the input transfer enters EXEC and starts the registered RAM read
//   of the second-of-stack; the result is registered on leaving EXEC, which
//   waits while the previous result still awaits its transfer. A new
//   instruction is taken only in IDLE, after the last one has left EXEC.
// Reset: arst_n clears the entry count, the error flag and the handshake
//   state; the stack RAM is not cleared and entries above the count are unused.
`default_nettype none
`include "stack_machine_20bit_unit_macros.svh"

module stack_machine_20bit_unit #(
	parameter int STACK_DEPTH = sm20_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [sm20_pkg::MODE_W-1:0]   mode,
	input  wire logic [sm20_pkg::WORD_W-1:0]   value,
	input  wire logic                          first,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [sm20_pkg::WORD_W-1:0]   top_value,
	output logic                               failed,
	output logic      [sm20_pkg::FILL_W-1:0]   fill
);

	localparam int FW     = $clog2(STACK_DEPTH + 1);
	localparam int AW     = $clog2(STACK_DEPTH);
	localparam int WW     = sm20_pkg::WORD_W;
	localparam int FILL_W = sm20_pkg::FILL_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                          state_q;
	logic [FW-1:0]                 cnt_q;
	logic                          err_q;
	logic [WW-1:0]                 tos_q;
	logic [sm20_pkg::MODE_W-1:0]   mode_s1;
	logic [WW-1:0]                 value_s1;
	logic                          out_valid_q;
	logic [WW-1:0]                 top_value_q;
	logic                          failed_q;
	logic [FILL_W-1:0]             fill_q;

	logic                          in_xfer;
	logic                          advance;
	logic [FW-1:0]                 rd_idx;
	logic [WW-1:0]                 nos;
	logic [FW-1:0]                 cnt_nxt;
	logic [WW-1:0]                 tos_nxt;
	logic [AW-1:0]                 waddr;
	logic [WW-1:0]                 wdata;
	sm20_pkg::exec_flags_t         flags;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign advance  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	// Second-of-stack address, read on the input transfer.
	assign rd_idx = cnt_q - FW'(2);

	sm20_ram #(
		.WIDTH (WW),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (advance && flags.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (in_xfer),
		.raddr (rd_idx[AW-1:0]),
		.rdata (nos)
	);

	sm20_exec #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_exec (
		.mode    (mode_s1),
		.value   (value_s1),
		.cnt     (cnt_q),
		.err     (err_q),
		.tos     (tos_q),
		.nos     (nos),
		.cnt_nxt (cnt_nxt),
		.tos_nxt (tos_nxt),
		.waddr   (waddr),
		.wdata   (wdata),
		.flags   (flags)
	);

	// Sequencer, entry count and sticky error.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_EXEC;
						if (first) begin
							cnt_q <= '0;
							err_q <= 1'b0;
						end
					end
				end
				ST_EXEC: begin
					if (advance) begin
						state_q <= ST_IDLE;
						cnt_q   <= cnt_nxt;
						err_q   <= flags.err;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Instruction capture and top-of-stack register.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1  <= mode;
			value_s1 <= value;
		end
		if (advance) begin
			tos_q <= tos_nxt;
		end
	end

	// Result register; it holds until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			top_value_q <= flags.fail ? '0 : tos_nxt;
			failed_q    <= flags.fail;
			fill_q      <= FILL_W'(cnt_nxt);
		end
	end

	assign out_valid = out_valid_q;
	assign top_value = top_value_q;
	assign failed    = failed_q;
	assign fill      = fill_q;

	// Checks on the sequencer and the stack state.
	`SM20_ASSERT_NEXT(a_xfer_to_exec, clk, arst_n, in_xfer, state_q == ST_EXEC)
	`SM20_ASSERT_NEXT(a_advance_gives_result, clk, arst_n, advance, out_valid_q)
	`SM20_ASSERT_NOW(a_cnt_in_range, clk, arst_n, 1'b1, cnt_q <= FW'(STACK_DEPTH))
	`SM20_ASSERT_NOW(a_failed_zero_top, clk, arst_n, out_valid_q && failed_q, top_value_q == '0)

endmodule

`default_nettype wire

>>> verif/stack_machine_20bit_unit_tb.sv
// -----------------------------------------------------------------------------
// stack_machine_20bit_unit_tb
// Self-checking bench for the 20-bit stack machine. A directed table covers the
// word extremes, every instruction, the sticky error and the clear flag. One
// run fills the stack to capacity and overflows it. Random instruction streams
// follow. An in-bench shadow stack predicts each untyped result, and results
// are compared field by field in order. Both handshakes idle at random.
// -----------------------------------------------------------------------------
`default_nettype none

module stack_machine_20bit_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sm20_pkg::*;

	localparam int STACK_DEPTH = STACK_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 200;

	// Unassigned instruction codes; the block must leave the stack alone.
	localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

	typedef struct packed {
		logic [WORD_W-1:0] top_word;
		logic              failed;
		logic [FILL_W-1:0] count;
	} stack_result_t;

	typedef struct packed {
		logic [MODE_W-1:0] op;
		logic [WORD_W-1:0] val;
		logic              clr;
		logic              typed;
		stack_result_t     res;
	} instr_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TICK, RX_HOLD} rx_pattern_t;

	// Directed instructions. Rows with typed set carry a hand-derived result.
	localparam int DIR_N = 26;
	localparam instr_row_t DIR_ROWS [DIR_N] = '{
		'{MODE_POP,    20'h00000, 1'b0, 1'b1, '{20'h00000, 1'b1, 12'd0}},
		'{MODE_PUSH,   20'h00005, 1'b0, 1'b1, '{20'h00000, 1'b1, 12'd0}},
		'{MODE_PUSH,   20'hFFFFF, 1'b1, 1'b1, '{20'hFFFFF, 1'b0, 12'd1}},
		'{MODE_PUSH,   20'h00001, 1'b0, 1'b1, '{20'h00001, 1'b0, 12'd2}},
		'{MODE_ADD,    20'h00000, 1'b0, 1'b1, '{20'h00000, 1'b1, 12'd2}},
		'{MODE_PUSH,   20'h00000, 1'b1, 1'b1, '{20'h00000, 1'b0, 12'd1}},
		'{MODE_PUSH,   20'h12345, 1'b0, 1'b0, '0},
		'{MODE_DUP,    20'h00000, 1'b0, 1'b0, '0},
		'{MODE_ADD,    20'h00000, 1'b0, 1'b0, '0},
		'{MODE_PUSH,   20'h00010, 1'b0, 1'b0, '0},
		'{MODE_SUB,    20'h00000, 1'b0, 1'b1, '{20'h00000, 1'b1, 12'd3}},
		'{MODE_PUSH,   20'h00003, 1'b1, 1'b0, '0},
		'{MODE_PUSH,   20'h00007, 1'b0, 1'b0, '0},
		'{MODE_SUB,    20'h00000, 1'b0, 1'b0, '0},
		'{MODE_SPARE5, 20'hFFFFF, 1'b0, 1'b0, '0},
		'{MODE_SPARE6, 20'h00000, 1'b0, 1'b0, '0},
		'{MODE_SPARE7, 20'hAAAAA, 1'b0, 1'b0, '0},
		'{MODE_POP,    20'h55555, 1'b0, 1'b1, '{20'h00000, 1'b1, 12'd0}},
		'{MODE_PUSH,   20'hAAAAA, 1'b0, 1'b0, '0},
		'{MODE_PUSH,   20'h55555, 1'b0, 1'b0, '0},
		'{MODE_ADD,    20'h00000, 1'b0, 1'b0, '0},
		'{MODE_DUP,    20'h00000, 1'b0, 1'b0, '0},
		'{MODE_SUB,    20'h00000, 1'b0, 1'b0, '0},
		'{MODE_POP,    20'h00000, 1'b1, 1'b1, '{20'h00000, 1'b1, 12'd0}},
		'{MODE_DUP,    20'h00000, 1'b1, 1'b1, '{20'h00000, 1'b1, 12'd0}},
		'{MODE_ADD,    20'h00000, 1'b1, 1'b1, '{20'h00000, 1'b1, 12'd0}}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [MODE_W-1:0]   mode = '0;
	logic [WORD_W-1:0]   value = '0;
	logic                first = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b1;
	logic [WORD_W-1:0]   top_value;
	logic                failed;
	logic [FILL_W-1:0]   fill;

	// Shadow copy of the machine state.
	logic [WORD_W-1:0]   shadow_stack [STACK_DEPTH];
	int unsigned         shadow_fill = 0;
	bit                  shadow_err = 1'b0;

	stack_result_t       expected_q [$];
	int unsigned         fail_count = 0;
	int unsigned         burst_left = 0;
	rx_pattern_t         rx_pattern = RX_OPEN;
	int unsigned         rx_left = 0;

	stack_machine_20bit_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.value    (value),
		.first    (first),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.top_value(top_value),
		.failed   (failed),
		.fill     (fill)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one instruction to the shadow stack and returns the result it gives.
	function automatic stack_result_t step_stack(input logic [MODE_W-1:0] op,
			input logic [WORD_W-1:0] val, input logic clr);
		logic [WORD_W-1:0] upper;
		logic [WORD_W-1:0] lower;
		logic [WORD_W:0]   total;
		stack_result_t     res;
		if (clr) begin
			shadow_fill = 0;
			shadow_err = 1'b0;
		end
		if (!shadow_err) begin
			case (op)
				MODE_PUSH: begin
					if (shadow_fill >= STACK_DEPTH) begin
						shadow_err = 1'b1;
					end else begin
						shadow_stack[shadow_fill] = val;
						shadow_fill++;
					end
				end
				MODE_POP: begin
					if (shadow_fill == 0) shadow_err = 1'b1;
					else shadow_fill--;
				end
				MODE_DUP: begin
					if (shadow_fill == 0 || shadow_fill >= STACK_DEPTH) begin
						shadow_err = 1'b1;
					end else begin
						shadow_stack[shadow_fill] = shadow_stack[shadow_fill - 1];
						shadow_fill++;
					end
				end
				MODE_ADD, MODE_SUB: begin
					if (shadow_fill < 2) begin
						shadow_err = 1'b1;
					end else begin
						upper = shadow_stack[shadow_fill - 1];
						lower = shadow_stack[shadow_fill - 2];
						// Bit 20 flags a carry out of the add or a borrow in the subtract.
						total = (op == MODE_ADD) ? {1'b0, upper} + {1'b0, lower}
							: {1'b0, upper} - {1'b0, lower};
						if (total[WORD_W]) begin
							shadow_err = 1'b1;
						end else begin
							shadow_fill--;
							shadow_stack[shadow_fill - 1] = total[WORD_W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.failed = shadow_err || shadow_fill == 0;
		res.top_word = res.failed ? '0 : shadow_stack[shadow_fill - 1];
		res.count = shadow_fill[FILL_W-1:0];
		return res;
	endfunction

	// Words biased toward small values so that adds and subtracts often succeed.
	function automatic logic [WORD_W-1:0] pick_word();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: return '0;
			1: return '1;
			2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			3, 4, 5: return WORD_W'($urandom_range(0, 255));
			default: return WORD_W'($urandom);
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Drives one instruction, waits for its transfer and records the expected result.
	// The sender works in bursts; a gap opens before each new burst.
	task automatic send_instr(input logic [MODE_W-1:0] op, input logic [WORD_W-1:0] val,
			input logic clr, input logic typed, input stack_result_t typed_res);
		stack_result_t predicted;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= op;
		value <= val;
		first <= clr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = step_stack(op, val, clr);
		expected_q.push_back(typed ? typed_res : predicted);
	endtask

	// Holds the sender off until every outstanding result has been transferred.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// Clears the stack, fills it to capacity, overflows it by push or duplicate, then sends a pop.
	task automatic fill_to_capacity(input bit dup_last);
		logic [MODE_W-1:0] op;
		send_instr(MODE_PUSH, pick_word(), 1'b1, 1'b0, '0);
		while (shadow_fill < STACK_DEPTH) begin
			op = ($urandom_range(0, 3) == 0) ? MODE_DUP : MODE_PUSH;
			send_instr(op, pick_word(), 1'b0, 1'b0, '0);
		end
		send_instr(dup_last ? MODE_DUP : MODE_PUSH, pick_word(), 1'b0, 1'b0, '0);
		send_instr(MODE_POP, pick_word(), 1'b0, 1'b0, '0);
	endtask

	// Mostly well-formed instruction streams; after an error, noise until a clear.
	task automatic run_random(input int unsigned n);
		int unsigned       counted;
		int unsigned       sel;
		logic [MODE_W-1:0] op;
		logic              clr;
		counted = 0;
		while (counted < n) begin
			if (shadow_err) begin
				clr = ($urandom_range(0, 2) == 0);
				op = MODE_W'($urandom_range(0, 7));
			end else begin
				clr = ($urandom_range(0, 59) == 0);
				sel = $urandom_range(0, 99);
				if (shadow_fill == 0 && sel < 90) op = MODE_PUSH;
				else if (sel < 30) op = MODE_PUSH;
				else if (sel < 45) op = MODE_POP;
				else if (sel < 58) op = MODE_DUP;
				else if (sel < 72) op = MODE_ADD;
				else if (sel < 86) op = MODE_SUB;
				else if (sel < 97) op = MODE_PUSH;
				else if (sel == 97) op = MODE_SPARE5;
				else if (sel == 98) op = MODE_SPARE6;
				else op = MODE_SPARE7;
			end
			if (clr || !shadow_err) counted++;
			send_instr(op, pick_word(), clr, 1'b0, '0);
		end
	endtask

	// Receiver stalls follow a pattern that is redrawn whenever its countdown rx_left runs out.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(64, 256);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_pattern)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_TICK: out_ready <= (rx_left[1:0] != 2'd0);
			RX_HOLD: out_ready <= (rx_left[3:0] < 4'd4);
			default: out_ready <= 1'b1;
		endcase
	end

	// Each result transfer is compared with the oldest expected result.
	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with no expected result: top_value %0h", top_value);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				check_field("top_value", 32'(want.top_word), 32'(top_value));
				check_field("failed", 32'(want.failed), 32'(failed));
				check_field("fill", 32'(want.count), 32'(fill));
			end
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_N; i++) begin
			send_instr(DIR_ROWS[i].op, DIR_ROWS[i].val, DIR_ROWS[i].clr,
				DIR_ROWS[i].typed, DIR_ROWS[i].res);
		end
		wait_drained();
		fill_to_capacity(1'b1);
		wait_drained();
		run_random(RANDOM_ITEMS);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#8000000;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
